/* rtl/fl_pkg.sv */
// Shared types and constants for the stereo flanger.
package fl_pkg;

   localparam int DEPTH_W    = 12;
   localparam int MOD_W      = 16;
   localparam int GAIN_W     = 16;
   localparam int FRAC_W     = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [GAIN_W:0] ONE_Q15 = 17'd32768;
   localparam int ROUND_Q15   = 16384;
   localparam int ROUND_FRAC  = 128;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_EFFECT_ON = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEPTH     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FEEDBACK  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_WET       = 2'd3;

   // datapath commands from the sequencer
   typedef struct packed {
      logic load;    // capture request, form depth * mod
      logic addr;    // compute taps, read history
      logic blend;   // interpolate taps
      logic mul;     // feedback / dry / wet products
      logic fin;     // load output register
      logic write;   // write history, advance pointer
      logic bypass;  // current request passes straight through
   } fl_cmd_type;

endpackage

/* rtl/fl_ctrl.sv */
// Sequencer for the flanger datapath and the response valid flag.
module fl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               effect_on,
   output fl_pkg::fl_cmd_type cmd
);
   import fl_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ADDR  = 3'd1;
   localparam logic [2:0] ST_BLEND = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       bypass_ff, bypass_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       fin_go;
   logic       accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fin_go    = (state_ff == ST_FIN) && out_free;
   assign req_ready = (state_ff == ST_IDLE) || fin_go;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      bypass_in    = bypass_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fin_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         bypass_in = !effect_on;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = effect_on ? ST_ADDR : ST_FIN;
            end
         end
         ST_ADDR:  state_in = ST_BLEND;
         ST_BLEND: state_in = ST_MUL;
         ST_MUL:   state_in = ST_FIN;
         ST_FIN: begin
            if (fin_go) begin
               if (accept) begin
                  state_in = effect_on ? ST_ADDR : ST_FIN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bypass_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bypass_ff    <= bypass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd.load   = accept;
      cmd.addr   = (state_ff == ST_ADDR);
      cmd.blend  = (state_ff == ST_BLEND);
      cmd.mul    = (state_ff == ST_MUL);
      cmd.fin    = fin_go;
      cmd.write  = fin_go && !bypass_ff;
      cmd.bypass = bypass_ff;
   end

endmodule

/* rtl/fl_wptr.sv */
// History write pointer and wrap flag shared by both channels.
module fl_wptr #(
   parameter int DELAY_LEN = 4096,
   localparam int ADDR_W = $clog2(DELAY_LEN)
) (
   input  logic               clock,
   input  logic               reset,
   input  fl_pkg::fl_cmd_type cmd,
   output logic [ADDR_W-1:0]  wp,
   output logic               wrapped
);
   import fl_pkg::*;

   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DELAY_LEN - 1);

   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic              wrapped_ff, wrapped_in;

   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (cmd.write) begin
         if (wp_ff == LAST) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
      end
   end

   assign wp      = wp_ff;
   assign wrapped = wrapped_ff;

endmodule

/* rtl/fl_chan.sv */
// One channel: delay memory, tap interpolation, feedback and dry/wet mix.
module fl_chan #(
   parameter int SAMPLE_BITS = 24,
   parameter int DELAY_LEN = 4096,
   localparam int ADDR_W = $clog2(DELAY_LEN)
) (
   input  logic                          clock,
   input  fl_pkg::fl_cmd_type            cmd,
   input  logic [fl_pkg::DEPTH_W-1:0]    depth,
   input  logic [fl_pkg::GAIN_W-1:0]     feedback,
   input  logic [fl_pkg::GAIN_W-1:0]     wet,
   input  logic [ADDR_W-1:0]             wp,
   input  logic                          wrapped,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [fl_pkg::MOD_W-1:0]      mod,
   output logic signed [SAMPLE_BITS-1:0] out
);
   import fl_pkg::*;

   localparam int SB     = SAMPLE_BITS;
   localparam int PROD_W = DEPTH_W + MOD_W;
   localparam int IDX_W  = ((ADDR_W > DEPTH_W) ? ADDR_W : DEPTH_W) + 2;
   localparam int BL_W   = SB + FRAC_W + 2;
   localparam int PW     = SB + GAIN_W + 2;

   localparam logic [IDX_W-1:0] LEN_I  = IDX_W'(DELAY_LEN);
   localparam logic [IDX_W-1:0] DMAX_I = IDX_W'(DELAY_LEN - 2);
   localparam logic signed [PW-1:0] SMAX_P = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [PW-1:0] SMIN_P = {{(PW-SB+1){1'b1}}, {(SB-1){1'b0}}};

   logic [SB-1:0] hist_mem [DELAY_LEN];

   logic signed [SB-1:0] x_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic signed [SB-1:0] y0_ff, y1_ff;
   logic                 v0_ff, v1_ff;
   logic signed [SB-1:0] delayed_ff;
   logic signed [PW-1:0] fbp_ff, dryp_ff, wetp_ff;
   logic signed [SB-1:0] out_ff;

   logic [DEPTH_W-1:0]   d_whole;
   logic [FRAC_W-1:0]    d_frac;
   logic [IDX_W-1:0]     d_cl, base0, base1, idx0, idx1;
   logic [ADDR_W-1:0]    addr0, addr1;
   logic signed [SB-1:0] y0m, y1m;
   logic signed [SB:0]   diff;
   logic signed [BL_W-1:0] blend_sum;
   logic [GAIN_W:0]      wet_c, dry_c;
   logic signed [PW-1:0] fb_sum, st_w, mix;
   logic signed [SB-1:0] stored, mixed;

   function automatic logic signed [SB-1:0] sat(input logic signed [PW-1:0] v);
      logic signed [SB-1:0] r;
      if (v > SMAX_P) begin
         r = SMAX_P[SB-1:0];
      end else if (v < SMIN_P) begin
         r = SMIN_P[SB-1:0];
      end else begin
         r = v[SB-1:0];
      end
      return r;
   endfunction

   // tap positions: newest stored sample is wp - 1
   always_comb begin
      d_whole = prod_ff[PROD_W-1 -: DEPTH_W];
      d_frac  = prod_ff[PROD_W-DEPTH_W-1 -: FRAC_W];
      d_cl    = (IDX_W'(d_whole) > DMAX_I) ? DMAX_I : IDX_W'(d_whole);
      base0   = IDX_W'(wp) + LEN_I - IDX_W'(1) - d_cl;
      base1   = IDX_W'(wp) + LEN_I - IDX_W'(2) - d_cl;
      idx0    = (base0 >= LEN_I) ? base0 - LEN_I : base0;
      idx1    = (base1 >= LEN_I) ? base1 - LEN_I : base1;
      addr0   = idx0[ADDR_W-1:0];
      addr1   = idx1[ADDR_W-1:0];
   end

   // entries not yet written read as zero
   always_comb begin
      y0m       = v0_ff ? y0_ff : '0;
      y1m       = v1_ff ? y1_ff : '0;
      diff      = {y1m[SB-1], y1m} - {y0m[SB-1], y0m};
      blend_sum = {{2{y0m[SB-1]}}, y0m, {FRAC_W{1'b0}}}
                + BL_W'(diff * $signed({1'b0, d_frac}))
                + BL_W'(ROUND_FRAC);
   end

   always_comb begin
      wet_c = ({1'b0, wet} > ONE_Q15) ? ONE_Q15 : {1'b0, wet};
      dry_c = ONE_Q15 - wet_c;
   end

   always_comb begin
      fb_sum = fbp_ff + PW'(ROUND_Q15);
      st_w   = PW'(x_ff) + (fb_sum >>> 15);
      stored = sat(st_w);
      mix    = dryp_ff + wetp_ff + PW'(ROUND_Q15);
      mixed  = sat(mix >>> 15);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= sample;
         prod_ff <= PROD_W'(depth) * PROD_W'(mod);
      end
      if (cmd.addr) begin
         y0_ff <= hist_mem[addr0];
         y1_ff <= hist_mem[addr1];
         v0_ff <= wrapped || (addr0 < wp);
         v1_ff <= wrapped || (addr1 < wp);
      end
      if (cmd.blend) begin
         delayed_ff <= blend_sum[SB+FRAC_W-1:FRAC_W];
      end
      if (cmd.mul) begin
         fbp_ff  <= PW'(delayed_ff * $signed({1'b0, feedback}));
         dryp_ff <= PW'(x_ff * $signed({1'b0, dry_c}));
         wetp_ff <= PW'(delayed_ff * $signed({1'b0, wet_c}));
      end
      if (cmd.write) begin
         hist_mem[wp] <= stored;
      end
      if (cmd.fin) begin
         out_ff <= cmd.bypass ? x_ff : mixed;
      end
   end

   assign out = out_ff;

endmodule

/* rtl/stereo_modulated_delay_flanger.sv */
// Stereo flanger top level: configuration registers, sequencer, pointer, two channels.
//
// Usage:
//   Requests arrive on req_* (valid/ready): one stereo sample pair and a
//   Q0.16 modulation value per channel. Each request yields exactly one
//   response on rsp_* (valid/ready) with the mixed stereo pair.
//   Configuration is written through csr_we/csr_addr/csr_wdata while idle.
// Timing:
//   Effect on: each request steps through history read, tap blend, gain
//   multiply and finish, and no further request is taken until the
//   current one is in its finish step; the next is taken in the finish cycle.
//   Effect off: one request per cycle while responses are taken.
// Reset:
//   Configuration registers clear to zero, the effect is off and the
//   write pointer is at slot 0. History needs no clearing pass: a wrap
//   flag plus the pointer mark unwritten slots, which read as zero.
// Stalls:
//   The result sits in an output register; while it is not taken, the
//   block still accepts and processes one more request, then holds it in
//   the finish step until the output register frees.
module stereo_modulated_delay_flanger #(
   parameter int SAMPLE_BITS = 24,
   parameter int DELAY_LEN = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [SAMPLE_BITS-1:0]    req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0]    req_right_sample,
   input  logic [fl_pkg::MOD_W-1:0]         req_left_mod,
   input  logic [fl_pkg::MOD_W-1:0]         req_right_mod,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]    rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]    rsp_right_out,
   input  logic                             csr_we,
   input  logic [fl_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [fl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import fl_pkg::*;

   localparam int ADDR_W = $clog2(DELAY_LEN);

   logic               effect_on_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [GAIN_W-1:0]  feedback_ff;
   logic [GAIN_W-1:0]  wet_ff;

   fl_cmd_type        cmd;
   logic [ADDR_W-1:0] wp;
   logic              wrapped;

   always_ff @(posedge clock) begin
      if (reset) begin
         effect_on_ff <= 1'b0;
         depth_ff     <= '0;
         feedback_ff  <= '0;
         wet_ff       <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_EFFECT_ON: effect_on_ff <= csr_wdata[0];
            CSR_DEPTH:     depth_ff     <= csr_wdata[DEPTH_W-1:0];
            CSR_FEEDBACK:  feedback_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_WET:       wet_ff       <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   fl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .effect_on (effect_on_ff),
      .cmd       (cmd)
   );

   fl_wptr #(.DELAY_LEN(DELAY_LEN)) u_wptr (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .wp      (wp),
      .wrapped (wrapped)
   );

   fl_chan #(.SAMPLE_BITS(SAMPLE_BITS), .DELAY_LEN(DELAY_LEN)) u_left (
      .clock    (clock),
      .cmd      (cmd),
      .depth    (depth_ff),
      .feedback (feedback_ff),
      .wet      (wet_ff),
      .wp       (wp),
      .wrapped  (wrapped),
      .sample   (req_left_sample),
      .mod      (req_left_mod),
      .out      (rsp_left_out)
   );

   fl_chan #(.SAMPLE_BITS(SAMPLE_BITS), .DELAY_LEN(DELAY_LEN)) u_right (
      .clock    (clock),
      .cmd      (cmd),
      .depth    (depth_ff),
      .feedback (feedback_ff),
      .wet      (wet_ff),
      .wp       (wp),
      .wrapped  (wrapped),
      .sample   (req_right_sample),
      .mod      (req_right_mod),
      .out      (rsp_right_out)
   );

endmodule

/* rtl/fl_checker.sv */
// Port-level checks for the flanger, bound to the top level.
module fl_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   input logic signed [SAMPLE_BITS-1:0] rsp_right_out
);
   import fl_pkg::*;

   // requests taken but not yet answered
   logic [1:0] pend_ff, pend_in;

   always_comb begin
      pend_in = pend_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pend_in = pend_ff + 2'd1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_out)
                                  && $stable(rsp_right_out))
      else $error("stalled response changed");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without pending request");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two requests pending");

endmodule

bind stereo_modulated_delay_flanger fl_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_fl_checker (.*);
